// ===== rtl/core/rc_pulse_channel_conditioner_core_assert.svh =====
// Assertion macros shared by the pulse channel conditioner RTL.
// Needs nothing else; include with the bare file name.
`ifndef RC_PULSE_CHANNEL_CONDITIONER_CORE_ASSERT_SVH
`define RC_PULSE_CHANNEL_CONDITIONER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RPCC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rpcc assertion failed");

// Next-cycle implication, disabled during reset.
`define RPCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rpcc assertion failed");

`endif

// ===== rtl/core/rpcc_pkg.sv =====
// Types and constants for the pulse channel conditioner.
// No dependencies; imported by every module of the block.
package rpcc_pkg;

   localparam int unsigned PulseW  = 18;
   localparam int unsigned ServoW  = 11;
   localparam int unsigned CountW  = 8;
   localparam int unsigned SpeedW  = 15;
   localparam int unsigned ActionW = 3;

   typedef enum logic [ActionW-1:0] {
      ACT_YAW      = 3'd0,
      ACT_PITCH    = 3'd1,
      ACT_ENDPOINT = 3'd2,
      ACT_CONTROL  = 3'd3,
      ACT_DRIVE    = 3'd4,
      ACT_AUTO     = 3'd5
   } action_type;

   localparam logic [1:0] POS_UP     = 2'd0;
   localparam logic [1:0] POS_CENTER = 2'd1;
   localparam logic [1:0] POS_DOWN   = 2'd2;

   localparam logic [PulseW-1:0] PULSE_MIN     = 18'd100000;
   localparam logic [PulseW-1:0] PULSE_MAX     = 18'd200000;
   localparam logic [PulseW-1:0] PULSE_CENTER  = 18'd150000;
   localparam logic [PulseW-1:0] DRIVE_LOW_LIM = 18'd148000;
   localparam logic [PulseW-1:0] DRIVE_HI_LIM  = 18'd152000;
   localparam logic [PulseW-1:0] DRIVE_HI_BASE = 18'd159000;
   localparam logic [PulseW-1:0] AUTO_LIM      = 18'd102000;
   localparam logic [SpeedW-1:0] AUTO_BASE     = 15'd14000;
   localparam logic [PulseW-1:0] CTRL_LOW_LIM  = 18'd102000;
   localparam logic [PulseW-1:0] CTRL_HI_LIM   = 18'd198000;
   localparam logic [PulseW-1:0] EP_CTR_LOW    = 18'd149990;
   localparam logic [PulseW-1:0] EP_CTR_HIGH   = 18'd150010;
   localparam logic [PulseW-1:0] EP_LOW_LIM    = 18'd100010;
   localparam logic [PulseW-1:0] EP_HI_LIM     = 18'd199990;
   localparam logic [PulseW-1:0] EP_UP_LIM     = 18'd125000;
   localparam logic [PulseW-1:0] EP_DOWN_LIM   = 18'd175000;
   localparam logic [ServoW-1:0] SERVO_CENTER  = 11'd1500;
   localparam logic [11:0]       SERVO_MIN     = 12'd1000;
   localparam logic [11:0]       SERVO_MAX     = 12'd2000;
   localparam logic [11:0]       SERVO_SUM     = 12'd3000;
   localparam logic [CountW-1:0] ARM_RESET     = 8'd18;

   // Reciprocal constants: floor(x/100), floor(d*333/1000), floor(d*3/49).
   localparam logic [18:0] RECIP_100   = 19'd335545;    // shift 25
   localparam logic [25:0] RECIP_DRIVE = 26'd44694504;  // shift 27
   localparam logic [19:0] RECIP_AUTO  = 20'd1027177;   // shift 24

   typedef struct packed {
      logic [ActionW-1:0] action;
      logic [PulseW-1:0]  pulse_width;
   } item_type;

   typedef struct packed {
      logic [ServoW-1:0] yaw_out;
      logic [ServoW-1:0] pitch_out;
      logic [1:0]        endpoint_position;
      logic              control_position;
      logic [PulseW-1:0] drive_out;
      logic              drive_armed;
      logic [SpeedW-1:0] auto_speed_out;
      logic              auto_armed;
   } result_type;

   function automatic logic [CountW-1:0] bump(input logic [CountW-1:0] count);
      return (count == {CountW{1'b1}}) ? count : count + 1'b1;
   endfunction

endpackage

// ===== rtl/core/rpcc_input_stage.sv =====
// Input register of the pulse channel conditioner.
// Depends on rpcc_pkg.
module rpcc_input_stage
   import rpcc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  item_type req_item,
   input  logic     advance_ready,
   output logic     item_valid,
   output item_type item
);

   logic     valid_ff, valid_in;
   item_type item_ff;
   logic     accept;

   assign req_stall = valid_ff & ~advance_ready;
   assign accept    = req_valid & ~req_stall;
   assign valid_in  = req_stall ? valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== rtl/core/rpcc_channel_update.sv =====
// Channel state registers and per-transaction update logic.
// Depends on rpcc_pkg.
module rpcc_channel_update
   import rpcc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic [CountW-1:0] csr_write_data,
   input  logic              advance,
   input  item_type          item,
   output result_type        result
);

   logic [CountW-1:0] arm_ff;
   logic [ServoW-1:0] yaw_ff, yaw_in, pitch_ff, pitch_in;
   logic [PulseW-1:0] endpoint_ff, endpoint_in, control_ff, control_in;
   logic [PulseW-1:0] drive_val_ff, drive_val_in;
   logic              drive_en_ff, drive_en_in, auto_en_ff, auto_en_in;
   logic [CountW-1:0] drive_cnt_ff, drive_cnt_in, auto_cnt_ff, auto_cnt_in;
   logic [SpeedW-1:0] auto_speed_ff, auto_speed_in;

   logic [PulseW-1:0] p;
   logic [36:0]       scaled;
   logic [11:0]       servo;
   logic              servo_ok, pulse_ok;
   logic [15:0]       low_diff, high_diff;
   logic [17:0]       low_tri;
   logic [PulseW-1:0] low_val, high_val;
   logic [41:0]       high_prod;
   logic [16:0]       auto_diff;
   logic [36:0]       auto_prod;
   logic [SpeedW-1:0] auto_val;

   assign p        = item.pulse_width;
   assign scaled   = 37'(p) * 37'(RECIP_100);
   assign servo    = scaled[36:25];
   assign servo_ok = (servo >= SERVO_MIN) && (servo <= SERVO_MAX);
   assign pulse_ok = (p >= PULSE_MIN) && (p <= PULSE_MAX);

   // Drive mapping, low side: x * 3/4.
   assign low_diff = 16'(p - PULSE_MIN);
   assign low_tri  = {2'b00, low_diff} + {1'b0, low_diff, 1'b0};
   assign low_val  = PULSE_MIN + {2'b00, low_tri[17:2]};

   // Drive mapping, high side: x * 333/1000.
   assign high_diff = 16'(p - DRIVE_HI_LIM);
   assign high_prod = 42'(high_diff) * 42'(RECIP_DRIVE);
   assign high_val  = DRIVE_HI_BASE + {4'b0000, high_prod[40:27]};

   // Auto speed mapping: x * 3/49.
   assign auto_diff = 17'(p - AUTO_LIM);
   assign auto_prod = 37'(auto_diff) * 37'(RECIP_AUTO);
   assign auto_val  = AUTO_BASE + {2'b00, auto_prod[36:24]};

   always_comb begin
      yaw_in        = yaw_ff;
      pitch_in      = pitch_ff;
      endpoint_in   = endpoint_ff;
      control_in    = control_ff;
      drive_val_in  = drive_val_ff;
      drive_en_in   = drive_en_ff;
      drive_cnt_in  = drive_cnt_ff;
      auto_en_in    = auto_en_ff;
      auto_cnt_in   = auto_cnt_ff;
      auto_speed_in = auto_speed_ff;
      unique case (action_type'(item.action))
         ACT_YAW: begin
            if (servo_ok) yaw_in = ServoW'(SERVO_SUM - servo);
         end
         ACT_PITCH: begin
            if (servo_ok) pitch_in = ServoW'(servo);
         end
         ACT_ENDPOINT: begin
            if (pulse_ok && ((p > EP_CTR_LOW && p < EP_CTR_HIGH) ||
                             p < EP_LOW_LIM || p > EP_HI_LIM)) begin
               endpoint_in = p;
            end
         end
         ACT_CONTROL: begin
            if (pulse_ok && (p < CTRL_LOW_LIM || p > CTRL_HI_LIM)) control_in = p;
         end
         ACT_DRIVE: begin
            if (pulse_ok) begin
               if (!drive_en_ff && drive_val_ff > DRIVE_LOW_LIM &&
                   drive_val_ff < DRIVE_HI_LIM) begin
                  drive_cnt_in = (p < DRIVE_LOW_LIM || p > DRIVE_HI_LIM) ?
                                 bump(drive_cnt_ff) : '0;
                  if (drive_cnt_in == arm_ff) drive_en_in = 1'b1;
               end
               if (drive_en_in) begin
                  priority if (p <= DRIVE_LOW_LIM) begin
                     drive_val_in = low_val;
                  end else if (p >= DRIVE_HI_LIM) begin
                     drive_val_in = high_val;
                  end else begin
                     drive_en_in  = 1'b0;
                     drive_val_in = PULSE_CENTER;
                  end
               end
            end
         end
         ACT_AUTO: begin
            if (pulse_ok) begin
               if (!auto_en_ff) begin
                  auto_cnt_in = (p > AUTO_LIM) ? bump(auto_cnt_ff) : '0;
                  if (auto_cnt_in == arm_ff) auto_en_in = 1'b1;
               end
               if (auto_en_in) begin
                  if (p > AUTO_LIM) begin
                     auto_speed_in = auto_val;
                  end else begin
                     auto_en_in    = 1'b0;
                     auto_speed_in = '0;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         arm_ff <= ARM_RESET;
      end else if (csr_write_enable) begin
         arm_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         yaw_ff        <= SERVO_CENTER;
         pitch_ff      <= SERVO_CENTER;
         endpoint_ff   <= PULSE_CENTER;
         control_ff    <= PULSE_CENTER;
         drive_val_ff  <= PULSE_CENTER;
         drive_en_ff   <= 1'b0;
         drive_cnt_ff  <= '0;
         auto_en_ff    <= 1'b0;
         auto_cnt_ff   <= '0;
         auto_speed_ff <= '0;
      end else if (advance) begin
         yaw_ff        <= yaw_in;
         pitch_ff      <= pitch_in;
         endpoint_ff   <= endpoint_in;
         control_ff    <= control_in;
         drive_val_ff  <= drive_val_in;
         drive_en_ff   <= drive_en_in;
         drive_cnt_ff  <= drive_cnt_in;
         auto_en_ff    <= auto_en_in;
         auto_cnt_ff   <= auto_cnt_in;
         auto_speed_ff <= auto_speed_in;
      end
   end

   always_comb begin
      result.yaw_out   = yaw_in;
      result.pitch_out = pitch_in;
      priority if (endpoint_in < EP_UP_LIM) begin
         result.endpoint_position = POS_UP;
      end else if (endpoint_in > EP_DOWN_LIM) begin
         result.endpoint_position = POS_DOWN;
      end else begin
         result.endpoint_position = POS_CENTER;
      end
      result.control_position = (control_in >= PULSE_CENTER);
      result.drive_out        = drive_val_in;
      result.drive_armed      = drive_en_in;
      result.auto_speed_out   = auto_speed_in;
      result.auto_armed       = auto_en_in;
   end

endmodule

// ===== rtl/core/rpcc_output_stage.sv =====
// Result register of the pulse channel conditioner.
// Depends on rpcc_pkg.
module rpcc_output_stage
   import rpcc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       item_valid,
   input  result_type result_next,
   output logic       ready,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output result_type rsp_result
);

   logic       valid_ff, valid_in;
   result_type result_ff;

   // Take a new result when empty or when the held one leaves this cycle.
   assign ready    = ~valid_ff | ~rsp_stall;
   assign valid_in = ready ? item_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready && item_valid) begin
         result_ff <= result_next;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

// ===== rtl/core/rc_pulse_channel_conditioner_core.sv =====
// Pulse channel conditioner: validates tagged RC pulse-width samples and keeps
// conditioned yaw, pitch, switch, drive and auto speed values.
// Request channel: req_valid/req_stall with req_action and req_pulse_width.
// Response channel: rsp_valid/rsp_stall with every conditioned value per
// transaction; each request yields exactly one response, in order.
// An accepted request passes two register stages, input register then result
// register, before its response shows. Throughput: one transaction per cycle
// unless the receiver stalls; all channel logic sits between the two registers
// and the channel state updates as the transaction moves on.
// When the receiver stalls, the result register holds and the input register
// still takes one more request; req_stall rises once both are full.
// csr_write_enable/csr_write_data set the arm sample count; write it only
// while no transaction is in flight.
// Reset (synchronous, active high) empties both stages, sets the arm count to
// 18, centers yaw, pitch, both switches and drive, and disarms drive and auto.
`include "rc_pulse_channel_conditioner_core_assert.svh"
module rc_pulse_channel_conditioner_core
   import rpcc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [CountW-1:0]   csr_write_data,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [ActionW-1:0]  req_action,
   input  logic [PulseW-1:0]   req_pulse_width,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [ServoW-1:0]   rsp_yaw_out,
   output logic [ServoW-1:0]   rsp_pitch_out,
   output logic [1:0]          rsp_endpoint_position,
   output logic                rsp_control_position,
   output logic [PulseW-1:0]   rsp_drive_out,
   output logic                rsp_drive_armed,
   output logic [SpeedW-1:0]   rsp_auto_speed_out,
   output logic                rsp_auto_armed
);

   item_type   req_item, item;
   logic       item_valid, out_ready, advance;
   result_type result_next, rsp_result;

   assign req_item.action      = req_action;
   assign req_item.pulse_width = req_pulse_width;
   assign advance              = item_valid & out_ready;

   rpcc_input_stage u_input (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_item     (req_item),
      .advance_ready(out_ready),
      .item_valid   (item_valid),
      .item         (item)
   );

   rpcc_channel_update u_update (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .advance         (advance),
      .item            (item),
      .result          (result_next)
   );

   rpcc_output_stage u_output (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .result_next(result_next),
      .ready      (out_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (rsp_result)
   );

   assign rsp_yaw_out           = rsp_result.yaw_out;
   assign rsp_pitch_out         = rsp_result.pitch_out;
   assign rsp_endpoint_position = rsp_result.endpoint_position;
   assign rsp_control_position  = rsp_result.control_position;
   assign rsp_drive_out         = rsp_result.drive_out;
   assign rsp_drive_armed       = rsp_result.drive_armed;
   assign rsp_auto_speed_out    = rsp_result.auto_speed_out;
   assign rsp_auto_armed        = rsp_result.auto_armed;

   `RPCC_ASSERT_NEXT(a_advance_fills, clock, reset, advance, rsp_valid)
   `RPCC_ASSERT_IMPL(a_armed_off_center, clock, reset, rsp_valid && rsp_drive_armed, rsp_drive_out != PULSE_CENTER)
   `RPCC_ASSERT_IMPL(a_disarmed_center, clock, reset, rsp_valid && !rsp_drive_armed, rsp_drive_out == PULSE_CENTER)
   `RPCC_ASSERT_IMPL(a_auto_off_zero, clock, reset, rsp_valid && !rsp_auto_armed, rsp_auto_speed_out == '0)
   `RPCC_ASSERT_IMPL(a_yaw_range, clock, reset, rsp_valid, rsp_yaw_out >= 11'd1000 && rsp_yaw_out <= 11'd2000)

endmodule
